FILE: src/lrcp_pkg.sv
// ----------------------------------------------------------------------------
// lrcp_pkg
// Shared constants, register codes and the arctangent table for the lidar
// ring/column projection.
// ----------------------------------------------------------------------------
package lrcp_pkg;

  localparam int COORD_BITS_DEFAULT = 20;
  localparam int ANGLE_BITS_DEFAULT = 16;

  localparam int RING_BITS   = 8;
  localparam int COLUMN_BITS = 12;
  localparam int ADDR_BITS   = 20;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 12;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RING_COUNT   = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 1'd1;

  localparam logic [RING_BITS-1:0]   RING_COUNT_RESET   = 8'd64;
  localparam logic [COLUMN_BITS-1:0] COLUMN_COUNT_RESET = 12'd2083;

  // angles are fractions of a full turn, 2^32 per turn
  localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

  // atan(2^-i) in turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

FILE: src/lrcp_point_if.sv
// ----------------------------------------------------------------------------
// lrcp_point_if
// Valid/ready channel carrying one lidar point item.
// ----------------------------------------------------------------------------
interface lrcp_point_if #(
  parameter int COORD_BITS = 20
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         first_of_cloud;

  modport source (output valid, point_x, point_y, first_of_cloud, input ready);
  modport sink   (input valid, point_x, point_y, first_of_cloud, output ready);
endinterface

FILE: src/lrcp_result_if.sv
// ----------------------------------------------------------------------------
// lrcp_result_if
// Valid/ready channel carrying one grid placement item.
// ----------------------------------------------------------------------------
interface lrcp_result_if ();
  logic        valid;
  logic        ready;
  logic        placed;
  logic [7:0]  row_index;
  logic [11:0] column_index;
  logic [19:0] cell_address;

  modport source (output valid, placed, row_index, column_index, cell_address,
                  input ready);
  modport sink   (input valid, placed, row_index, column_index, cell_address,
                  output ready);
endinterface

FILE: src/lrcp_cordic.sv
// ----------------------------------------------------------------------------
// lrcp_cordic
// Iterative vectoring CORDIC: one micro-rotation per cycle, returns the
// azimuth of (x, y) as an unsigned binary angle over a full turn.
// ----------------------------------------------------------------------------
module lrcp_cordic
  import lrcp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] x_in,
  input  logic signed [COORD_BITS-1:0] y_in,
  output logic                         done,
  output logic [ANGLE_BITS-1:0]        angle
);

  // 24 fraction bits plus headroom for the gain and the quarter turn
  localparam int W  = COORD_BITS + 26;
  localparam int IW = $clog2(ANGLE_BITS);
  localparam logic [IW-1:0] LAST_STEP = IW'(ANGLE_BITS - 1);

  logic signed [W-1:0] x;
  logic signed [W-1:0] y;
  logic [31:0]         z;
  logic [IW-1:0]       step;
  logic                busy;
  logic                origin;

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;
  logic [31:0]         z_round;

  assign xs = {{(W-COORD_BITS){x_in[COORD_BITS-1]}}, x_in} << 24;
  assign ys = {{(W-COORD_BITS){y_in[COORD_BITS-1]}}, y_in} << 24;

  assign dx = y >>> step;
  assign dy = x >>> step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      origin <= (x_in == '0) && (y_in == '0);
      // fold into the right half plane first
      if (x_in[COORD_BITS-1] && !y_in[COORD_BITS-1]) begin
        x <= ys;
        y <= -xs;
        z <= QUARTER_TURN;
      end else if (x_in[COORD_BITS-1]) begin
        x <= -ys;
        y <= xs;
        z <= THREE_QUARTER_TURN;
      end else begin
        x <= xs;
        y <= ys;
        z <= '0;
      end
    end else if (busy) begin
      if (!y[W-1]) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan_turn(5'(step));
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan_turn(5'(step));
      end
    end
  end

  // round half up to the top angle bits, wrapping at a full turn
  assign z_round = z + (32'd1 << (31 - ANGLE_BITS));
  assign angle   = origin ? '0 : z_round[31 -: ANGLE_BITS];

endmodule

FILE: src/lidar_ring_column_projection.sv
// ----------------------------------------------------------------------------
// lidar_ring_column_projection
// Projects lidar points onto a ring x column range image grid.
// ----------------------------------------------------------------------------
// a point to be placed passes ST_ROTATE, where the cordic does one step per
// cycle, then ST_COLMUL, ST_COLWRAP and ST_ADDRMUL to ST_DONE; a point that is
// not placed goes straight from ST_IDLE to ST_DONE; the result is registered
// when the output is free, and a new point is taken only back in ST_IDLE
// reset (synchronous, active high) sets ring_count 64, column_count 2083,
// current ring -1 and clears the azimuth history; there is no clearing pass
module lidar_ring_column_projection
  import lrcp_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT,
  parameter int ANGLE_BITS = ANGLE_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  lrcp_point_if.sink                point,
  lrcp_result_if.source             result,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_ROTATE  = 6'b000010,
    ST_COLMUL  = 6'b000100,
    ST_COLWRAP = 6'b001000,
    ST_ADDRMUL = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  localparam int PW = ANGLE_BITS + COLUMN_BITS;

  state_t state;
  state_t state_next;

  logic [RING_BITS-1:0]   ring_count;
  logic [COLUMN_BITS-1:0] column_count;
  logic signed [8:0]      current_ring;
  logic                   prev_nonpositive;

  logic                   place;
  logic [RING_BITS-1:0]   row;
  logic [COLUMN_BITS-1:0] col;
  logic [PW-1:0]          col_prod;
  logic [ADDR_BITS-1:0]   addr_prod;

  logic                   accept;
  logic                   positive;
  logic                   ring_step;
  logic signed [8:0]      ring_next;
  logic signed [8:0]      ring_limit;
  logic                   place_next;
  logic [PW-1:0]          col_round;
  logic [COLUMN_BITS-1:0] col_raw;
  logic                   out_free;

  logic                   cordic_done;
  logic [ANGLE_BITS-1:0]  angle;

  lrcp_cordic #(
    .COORD_BITS(COORD_BITS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (accept && place_next),
    .x_in  (point.point_x),
    .y_in  (point.point_y),
    .done  (cordic_done),
    .angle (angle)
  );

  assign point.ready = (state == ST_IDLE);
  assign accept      = point.valid && point.ready;
  assign out_free    = !result.valid || result.ready;

  // above zero: y > 0, or y == 0 with x < 0
  assign positive = (!point.point_y[COORD_BITS-1] && (point.point_y != '0)) ||
                    ((point.point_y == '0) && point.point_x[COORD_BITS-1]);

  assign ring_limit = $signed({1'b0, ring_count});
  assign ring_step  = prev_nonpositive && positive && (current_ring < ring_limit);

  always_comb begin
    if (point.first_of_cloud) begin
      ring_next  = positive ? 9'sd0 : -9'sd1;
      place_next = 1'b0;
    end else begin
      ring_next  = current_ring + (ring_step ? 9'sd1 : 9'sd0);
      place_next = !ring_next[8] && (ring_next < ring_limit) && (column_count != '0);
    end
  end

  // rounded column, at most one wrap since it never exceeds column_count
  assign col_round = col_prod + (PW'(1) << (ANGLE_BITS - 1));
  assign col_raw   = col_round[PW-1 -: COLUMN_BITS];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (accept) state_next = place_next ? ST_ROTATE : ST_DONE;
      ST_ROTATE:  if (cordic_done) state_next = ST_COLMUL;
      ST_COLMUL:  state_next = ST_COLWRAP;
      ST_COLWRAP: state_next = ST_ADDRMUL;
      ST_ADDRMUL: state_next = ST_DONE;
      ST_DONE:    if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      ring_count       <= RING_COUNT_RESET;
      column_count     <= COLUMN_COUNT_RESET;
      current_ring     <= -9'sd1;
      prev_nonpositive <= 1'b0;
      result.valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_RING_COUNT:   ring_count   <= cfg_data[RING_BITS-1:0];
          REG_COLUMN_COUNT: column_count <= cfg_data;
          default:          ;
        endcase
      end
      if (accept) begin
        current_ring     <= ring_next;
        prev_nonpositive <= !positive;
      end
      if (state == ST_DONE && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      place <= place_next;
      row   <= ring_next[RING_BITS-1:0];
    end
    if (state == ST_COLMUL) begin
      col_prod <= PW'(angle) * PW'(column_count);
    end
    if (state == ST_COLWRAP) begin
      col <= (col_raw >= column_count) ? col_raw - column_count : col_raw;
    end
    if (state == ST_ADDRMUL) begin
      addr_prod <= ADDR_BITS'(row) * ADDR_BITS'(column_count);
    end
    if (state == ST_DONE && out_free) begin
      result.placed       <= place;
      result.row_index    <= place ? row : '0;
      result.column_index <= place ? col : '0;
      result.cell_address <= place ? addr_prod + ADDR_BITS'(col) : '0;
    end
  end

endmodule

FILE: dv/lidar_ring_column_projection_checker.sv
// ----------------------------------------------------------------------------
// lidar_ring_column_projection_checker
// Watches the point and result channels and the register port of the ring/
// column projection. It keeps its own ring tracker and cordic azimuth, works
// out the grid placement of each accepted point and compares every accepted
// result with the oldest placement still waiting.
// ----------------------------------------------------------------------------
module lidar_ring_column_projection_checker
  import lrcp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  lrcp_point_if                     point,
  lrcp_result_if                    result,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        errors,
  output int                        outstanding
);

  localparam int CW      = COORD_BITS_DEFAULT;
  localparam int ANGLE_W = ANGLE_BITS_DEFAULT;

  // atan(2^-i) as a fraction of a full turn, entry 0 in the low word
  localparam logic [23:0][31:0] ATAN_TURN = {
    32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C,
    32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
    32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
    32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
    32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
    32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
  };

  typedef struct packed {
    logic                   placed;
    logic [RING_BITS-1:0]   row;
    logic [COLUMN_BITS-1:0] col;
    logic [ADDR_BITS-1:0]   addr;
  } placement_t;

  logic [RING_BITS-1:0]   ring_cnt;
  logic [COLUMN_BITS-1:0] col_cnt;
  int                     ring_now;
  logic                   last_nonpositive;
  placement_t             placement_q[$];

  // binary angle over [0, 360) by vectoring cordic
  function automatic logic [ANGLE_W-1:0] cordic_azimuth(input longint px, input longint py);
    longint      x, y, t, dx, dy;
    logic [31:0] z;
    logic [32:0] r;
    int          i;
    if (px == 0 && py == 0) return '0;
    x = px <<< 24;
    y = py <<< 24;
    z = '0;
    // fold into the right half plane first
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = QUARTER_TURN;
      end else begin
        x = -y;
        y = t;
        z = THREE_QUARTER_TURN;
      end
    end
    for (i = 0; i < ANGLE_W && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end
    end
    r = {1'b0, z} + (33'd1 << (31 - ANGLE_W));
    return r[31 -: ANGLE_W];
  endfunction

  function automatic placement_t project_point(input logic signed [CW-1:0] x_in,
                                               input logic signed [CW-1:0] y_in,
                                               input logic first);
    longint     px, py, u, c, a;
    logic       positive;
    placement_t p;
    px = x_in;
    py = y_in;
    p = '0;
    positive = (py > 0) || (py == 0 && px < 0);
    if (first) begin
      ring_now = positive ? 0 : -1;
    end else begin
      // ring advances on the step from nonpositive to positive azimuth
      if (last_nonpositive && positive && ring_now < int'(ring_cnt)) ring_now++;
      if (ring_now >= 0 && ring_now < int'(ring_cnt) && col_cnt != 0) begin
        u = longint'(cordic_azimuth(px, py));
        c = (u * longint'(col_cnt) + (64'sd1 <<< (ANGLE_W - 1))) >>> ANGLE_W;
        if (c >= longint'(col_cnt)) c = c - longint'(col_cnt);
        a = longint'(ring_now) * longint'(col_cnt) + c;
        p.placed = 1'b1;
        p.row    = RING_BITS'(ring_now);
        p.col    = COLUMN_BITS'(c);
        p.addr   = ADDR_BITS'(a);
      end
    end
    last_nonpositive = !positive;
    return p;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      ring_cnt         = RING_COUNT_RESET;
      col_cnt          = COLUMN_COUNT_RESET;
      ring_now         = -1;
      last_nonpositive = 1'b0;
      placement_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RING_COUNT:   ring_cnt = cfg_data[RING_BITS-1:0];
          REG_COLUMN_COUNT: col_cnt  = cfg_data[COLUMN_BITS-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (placement_q.size() == 0) begin
          $error("result item with no placement waiting");
          errors++;
        end else begin
          want = placement_q.pop_front();
          check_field("placed", want.placed, result.placed);
          check_field("row_index", want.row, result.row_index);
          check_field("column_index", want.col, result.column_index);
          check_field("cell_address", want.addr, result.cell_address);
        end
      end
      if (point.valid && point.ready)
        placement_q.insert(placement_q.size(),
                           project_point(point.point_x, point.point_y,
                                         point.first_of_cloud));
    end
    outstanding = placement_q.size();
  end

endmodule

FILE: dv/lidar_ring_column_projection_tb.sv
// ----------------------------------------------------------------------------
// lidar_ring_column_projection_tb
// Drives lidar points into the ring/column projection: a directed run over
// the coordinate extremes, cloud starts, ring saturation and empty grids,
// then random scan clouds with some noise under changing grid sizes and
// three idling patterns. The checker beside the block compares every item.
// ----------------------------------------------------------------------------
module lidar_ring_column_projection_tb;
  import lrcp_pkg::*;

  localparam int CW         = COORD_BITS_DEFAULT;
  localparam int QUIET_LIMIT = 5000;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        mismatch_count;
  int                        waiting_count;
  int                        src_idle;
  int                        snk_idle;
  int                        quiet_cycles;

  lrcp_point_if #(.COORD_BITS(CW)) point_ch ();
  lrcp_result_if                   result_ch ();

  lidar_ring_column_projection dut (
    .clk       (clk),
    .rst       (rst),
    .point     (point_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lidar_ring_column_projection_checker placement_checker (
    .clk         (clk),
    .rst         (rst),
    .point       (point_ch),
    .result      (result_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (mismatch_count),
    .outstanding (waiting_count)
  );

  always #5 clk = ~clk;

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready = !rst && ($urandom_range(99) >= snk_idle);
    end
  end

  // ends the run when nothing moves on either channel for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("lidar_ring_column_projection_tb: done, errors");
    $finish;
  end

  task automatic send_point(input int x, input int y, input logic first);
    while ($urandom_range(99) < src_idle) begin
      point_ch.valid = 1'b0;
      @(negedge clk);
    end
    point_ch.valid          = 1'b1;
    point_ch.point_x        = CW'(x);
    point_ch.point_y        = CW'(y);
    point_ch.first_of_cloud = first;
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    int                    t;
    logic signed [CW-1:0]  v;
    case ($urandom_range(3))
      0: v = CW'($urandom);
      1: begin
        t = $urandom_range(32);
        v = CW'(t - 16);
      end
      2: begin
        t = $urandom_range(8191);
        v = CW'(t - 4096);
      end
      default: begin
        case ($urandom_range(4))
          0:       v = {1'b1, {(CW-1){1'b0}}};
          1:       v = {1'b0, {(CW-1){1'b1}}};
          2:       v = '0;
          3:       v = '1;
          default: v = CW'(1);
        endcase
      end
    endcase
    return v;
  endfunction

  // random point forced into the positive or the nonpositive half of the turn
  task automatic send_shaped(input logic want_positive, input logic first);
    logic signed [CW-1:0] x, y;
    x = rand_coord();
    y = rand_coord();
    if (want_positive) begin
      if (y < 0) y = ~y;
      if (y == 0 && x >= 0) x = ~x;
    end else begin
      if (y > 0) y = ~y;
      if (y == 0 && x < 0) x = ~x;
    end
    send_point(int'(x), int'(y), first);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    point_ch.valid = 1'b0;
    while (waiting_count != 0) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic pick_grid(input int phase, input int blk);
    logic [RING_BITS-1:0]   rc;
    logic [COLUMN_BITS-1:0] cc;
    if (blk == 0 && phase == 0) begin
      rc = 8'd255;
      cc = 12'd1;
    end else if (blk == 0 && phase == 1) begin
      rc = 8'd1;
      cc = 12'd4095;
    end else begin
      case ($urandom_range(15))
        0:       rc = 8'd0;
        1, 2:    rc = 8'd255;
        3, 4:    rc = 8'd1;
        default: rc = RING_BITS'($urandom_range(12, 2));
      endcase
      case ($urandom_range(15))
        0:       cc = 12'd0;
        1, 2:    cc = 12'd4095;
        3:       cc = 12'd1;
        default: cc = COLUMN_BITS'($urandom_range(4095, 1));
      endcase
    end
    // upper bits of the data word are junk for the ring register
    write_reg(REG_RING_COUNT, {4'($urandom), rc});
    write_reg(REG_COLUMN_COUNT, cc);
  endtask

  // scan clouds: a start point, then rings of positive and nonpositive halves, mixed with stray random points
  task automatic random_traffic(input int n);
    int sent, rings, r, k, half_n;
    logic lead_positive;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(7) == 0) begin
        send_point(int'(rand_coord()), int'(rand_coord()), $urandom_range(15) == 0);
        sent++;
      end else begin
        send_shaped(1'($urandom_range(1)), 1'b1);
        sent++;
        rings = $urandom_range(14, 1);
        lead_positive = 1'($urandom_range(1));
        for (r = 0; r < rings; r++) begin
          half_n = $urandom_range(4, 1);
          for (k = 0; k < half_n; k++) send_shaped(lead_positive, 1'b0);
          sent += half_n;
          half_n = $urandom_range(4, 1);
          for (k = 0; k < half_n; k++) send_shaped(!lead_positive, 1'b0);
          sent += half_n;
        end
      end
    end
  endtask

  initial begin
    int phase, blk;
    rst                     = 1'b1;
    cfg_we                  = 1'b0;
    cfg_index               = REG_RING_COUNT;
    cfg_data                = '0;
    point_ch.valid          = 1'b0;
    point_ch.point_x        = '0;
    point_ch.point_y        = '0;
    point_ch.first_of_cloud = 1'b0;
    src_idle                = 25;
    snk_idle                = 58;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // points before any cloud start, origin and axis extremes
    send_point(0, 0, 1'b0);
    send_point(100, 50, 1'b0);
    send_point(-524288, 0, 1'b0);
    send_point(524287, 524287, 1'b1);
    send_point(524287, -524288, 1'b0);
    send_point(-524288, -524288, 1'b0);
    send_point(0, 524287, 1'b0);
    send_point(0, -1, 1'b0);
    send_point(524287, 0, 1'b0);
    send_point(-1, 1, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(5, -3, 1'b1);
    send_point(3, 4, 1'b0);
    // single ring grid, ring saturates
    write_reg(REG_RING_COUNT, 12'hA01);
    send_point(-7, -9, 1'b0);
    send_point(7, 9, 1'b0);
    send_point(1, -1, 1'b0);
    send_point(-1, 2, 1'b0);
    // no columns
    write_reg(REG_COLUMN_COUNT, 12'd0);
    send_point(3, 7, 1'b1);
    send_point(3, 7, 1'b0);
    // widest grid, column wraps just below a full turn
    write_reg(REG_COLUMN_COUNT, 12'd4095);
    write_reg(REG_RING_COUNT, 12'd255);
    send_point(2, 3, 1'b1);
    send_point(524287, -1, 1'b0);
    send_point(524287, 1, 1'b0);
    // ring count masked down to zero
    write_reg(REG_RING_COUNT, 12'h100);
    send_point(1, 1, 1'b1);
    send_point(-2, -2, 1'b0);
    send_point(2, 2, 1'b0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle = 25;
          snk_idle = 58;
        end
        1: begin
          src_idle = 58;
          snk_idle = 25;
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
        end
      endcase
      for (blk = 0; blk < 4; blk++) begin
        pick_grid(phase, blk);
        random_traffic(100);
      end
    end

    point_ch.valid = 1'b0;
    while (waiting_count != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (mismatch_count == 0)
      $display("lidar_ring_column_projection_tb: done, clean");
    else
      $display("lidar_ring_column_projection_tb: done, errors");
    $finish;
  end

endmodule

FILE: files.f
src/lrcp_pkg.sv
src/lrcp_point_if.sv
src/lrcp_result_if.sv
src/lrcp_cordic.sv
src/lidar_ring_column_projection.sv
dv/lidar_ring_column_projection_checker.sv
dv/lidar_ring_column_projection_tb.sv
